### hw/rtl/motor_speed_step_regulator_defines.svh
// assertion macros for the speed step regulator
`ifndef MOTOR_SPEED_STEP_REGULATOR_DEFINES_SVH
`define MOTOR_SPEED_STEP_REGULATOR_DEFINES_SVH

`ifndef SYNTH
`define MSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msr assertion failed");
`define MSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msr assertion failed");
`else
`define MSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/msr_pkg.sv
package msr_pkg;

    localparam int NOW_W             = 32;
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int SPEED_W           = 26;
    localparam int REF_W             = 16;
    localparam int FREQ_W            = 5;
    localparam int CODE_W            = 4;
    localparam int DIV_STEPS         = SPEED_W;
    localparam int CNT_W             = $clog2(DIV_STEPS);

    localparam logic [SPEED_W-1:0] SPEED_NUMERATOR = SPEED_W'(60000000);
    localparam logic [FREQ_W-1:0]  FREQ_MIN_HALF   = FREQ_W'(6);
    localparam logic [FREQ_W-1:0]  FREQ_MAX_HALF   = FREQ_W'(30);
    localparam logic [FREQ_W-1:0]  FREQ_RESET_HALF = FREQ_W'(20);
    localparam logic [REF_W-1:0]   REF_RESET       = REF_W'(250);
    localparam logic [CNT_W-1:0]   DIV_LAST        = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } msr_state_t;

    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_step;
        logic commit;
    } msr_cmd_t;

    typedef struct packed {
        logic rising_edge;
        logic period_zero;
    } msr_status_t;

endpackage

### hw/rtl/motor_speed_step_regulator.sv
// Speed step regulator: each input item carries a microsecond timestamp and the sensor
// level; each yields exactly one result item with the drive frequency code, the timing
// window pulse and the latest measured speed in rpm. An item is taken in the idle cycle,
// checked in the next, and its result is registered when the finish state commits it. An
// item without a rising sensor edge (or with a zero period) goes from the check state
// straight to the finish state; a rising edge with a non-zero period first runs the
// restoring divider, one quotient bit per cycle. The next item is accepted only after
// the last one has committed. A result left waiting on the output does not stop the
// next item from being accepted; only the following commit waits for the output register
// to empty.
// reference_speed is written through cfg_wr_en and cfg_wr_data and resets to 250 rpm.
module motor_speed_step_regulator #(
    parameter int TIME_BITS = msr_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [msr_pkg::NOW_W-1:0]    s_now_us,
    input  logic                         s_sensor_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [msr_pkg::CODE_W-1:0]   m_freq_code,
    output logic                         m_speed_pulse,
    output logic [msr_pkg::SPEED_W-1:0]  m_speed_rpm,
    input  logic                         cfg_wr_en,
    input  logic [msr_pkg::REF_W-1:0]    cfg_wr_data
);
    import msr_pkg::*;

    msr_cmd_t    cmd;
    msr_status_t status;

    msr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    msr_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_now_us       (s_now_us),
        .s_sensor_level (s_sensor_level),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_freq_code    (m_freq_code),
        .m_speed_pulse  (m_speed_pulse),
        .m_speed_rpm    (m_speed_rpm)
    );

endmodule

### hw/rtl/msr_ctrl.sv
`include "motor_speed_step_regulator_defines.svh"

module msr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  msr_pkg::msr_status_t status,
    output msr_pkg::msr_cmd_t    cmd
);
    import msr_pkg::*;

    msr_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.rising_edge && !status.period_zero) begin
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_CHECK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_FINISH: begin
                cmd.commit = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MSR_ASSERT_NEXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready, state_reg == ST_CHECK)
    `MSR_ASSERT_IMPLY(a_commit_slot_free, aclk, aresetn, cmd.commit, !out_valid_reg || m_ready)
    `MSR_ASSERT_NEXT(a_divide_ends, aclk, aresetn, state_reg == ST_DIVIDE && cnt_reg == DIV_LAST, state_reg == ST_FINISH)

endmodule

### hw/rtl/msr_datapath.sv
`include "motor_speed_step_regulator_defines.svh"

module msr_datapath #(
    parameter int TIME_BITS = msr_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  msr_pkg::msr_cmd_t            cmd,
    output msr_pkg::msr_status_t         status,
    input  logic [msr_pkg::NOW_W-1:0]    s_now_us,
    input  logic                         s_sensor_level,
    input  logic                         cfg_wr_en,
    input  logic [msr_pkg::REF_W-1:0]    cfg_wr_data,
    output logic [msr_pkg::CODE_W-1:0]   m_freq_code,
    output logic                         m_speed_pulse,
    output logic [msr_pkg::SPEED_W-1:0]  m_speed_rpm
);
    import msr_pkg::*;

    localparam int DIV_W = TIME_BITS + 1;
    localparam int SUM_W = (TIME_BITS > SPEED_W) ? TIME_BITS : SPEED_W;

    logic [REF_W-1:0]     ref_reg;
    logic                 prev_level_reg, prev_level_next;
    logic [TIME_BITS-1:0] last_edge_reg, last_edge_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic                 flag_reg, flag_next;
    logic [TIME_BITS-1:0] win_start_reg, win_start_next;
    logic [TIME_BITS-1:0] win_stop_reg, win_stop_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;

    logic [TIME_BITS-1:0] now_reg;
    logic                 level_reg;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [SPEED_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]     divisor_reg, divisor_next;

    logic [CODE_W-1:0]    code_reg;
    logic                 pulse_reg;
    logic [SPEED_W-1:0]   rpm_reg;

    logic [TIME_BITS-1:0] period;
    logic [DIV_W-1:0]     trial;
    logic                 trial_fits;
    logic [SUM_W-1:0]     stop_sum;
    logic                 in_window;
    logic [SPEED_W-1:0]   ref_ext;
    logic [FREQ_W-1:0]    freq_step;

    assign period             = now_reg - last_edge_reg;
    assign status.rising_edge = level_reg && !prev_level_reg;
    assign status.period_zero = (period == '0);

    // restoring divider, one quotient bit per cycle
    assign trial      = {rem_reg[DIV_W-2:0], quo_reg[SPEED_W-1]};
    assign trial_fits = (trial >= divisor_reg);

    always_comb begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (cmd.div_init) begin
            rem_next     = '0;
            quo_next     = SPEED_NUMERATOR;
            divisor_next = DIV_W'(period);
        end else if (cmd.div_step) begin
            rem_next = trial_fits ? (trial - divisor_reg) : trial;
            quo_next = {quo_reg[SPEED_W-2:0], trial_fits};
        end
    end

    always_comb begin
        speed_next      = speed_reg;
        flag_next       = flag_reg;
        last_edge_next  = last_edge_reg;
        if (status.rising_edge) begin
            last_edge_next = now_reg;
            if (status.period_zero) begin
                speed_next = SPEED_NUMERATOR;
                flag_next  = 1'b0;
            end else begin
                speed_next = quo_reg;
                flag_next  = (rem_reg != '0);
            end
        end
        prev_level_next = level_reg;
    end

    assign in_window = (now_reg < win_stop_reg) && (now_reg > win_start_reg);
    assign stop_sum  = SUM_W'(now_reg) + SUM_W'(speed_next);

    always_comb begin
        win_start_next = win_start_reg;
        win_stop_next  = win_stop_reg;
        if (!in_window) begin
            win_start_next = now_reg;
            win_stop_next  = stop_sum[TIME_BITS-1:0];
        end
    end

    assign ref_ext = SPEED_W'(ref_reg);

    always_comb begin
        freq_step = freq_reg;
        if (speed_next < ref_ext) begin
            freq_step = freq_reg + 1'b1;
        end else if ((speed_next > ref_ext) || flag_next) begin
            freq_step = freq_reg - 1'b1;
        end
        if (freq_step > FREQ_MAX_HALF) begin
            freq_next = FREQ_MAX_HALF;
        end else if (freq_step < FREQ_MIN_HALF) begin
            freq_next = FREQ_MIN_HALF;
        end else begin
            freq_next = freq_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg        <= REF_RESET;
            prev_level_reg <= 1'b0;
            last_edge_reg  <= '0;
            speed_reg      <= '0;
            flag_reg       <= 1'b0;
            win_start_reg  <= '0;
            win_stop_reg   <= '0;
            freq_reg       <= FREQ_RESET_HALF;
        end else begin
            if (cfg_wr_en) begin
                ref_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                prev_level_reg <= prev_level_next;
                last_edge_reg  <= last_edge_next;
                speed_reg      <= speed_next;
                flag_reg       <= flag_next;
                win_start_reg  <= win_start_next;
                win_stop_reg   <= win_stop_next;
                freq_reg       <= freq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg   <= TIME_BITS'(s_now_us);
            level_reg <= s_sensor_level;
        end
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        if (cmd.commit) begin
            code_reg  <= freq_next[FREQ_W-1:1];
            pulse_reg <= in_window;
            rpm_reg   <= speed_next;
        end
    end

    assign m_freq_code   = code_reg;
    assign m_speed_pulse = pulse_reg;
    assign m_speed_rpm   = rpm_reg;

    `MSR_ASSERT_IMPLY(a_freq_in_range, aclk, aresetn, 1'b1, freq_reg >= FREQ_MIN_HALF && freq_reg <= FREQ_MAX_HALF)
    `MSR_ASSERT_NEXT(a_code_tracks_freq, aclk, aresetn, cmd.commit, code_reg == freq_reg[FREQ_W-1:1])

endmodule
